>>> design/psa_pkg.sv
package psa_pkg;

  // Field widths of the command and result words
  localparam int SLOT_W    = 6;
  localparam int PRIO_W    = 8;
  localparam int VOL_W     = 7;
  localparam int CMD_W     = 2;
  localparam int ACT_W     = 6;

  // Configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOL_SCALE    = 1'b0,
    REG_ACTIVE_SLOTS = 1'b1
  } reg_idx_t;

  localparam logic [VOL_W-1:0] VOL_UNITY    = 7'h7f;
  localparam logic [ACT_W-1:0] ACTIVE_RESET = 6'd32;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  // Divide by 127: floor(x * 16514 / 2^21), exact for x below 16513
  localparam int PROD_W      = 2 * VOL_W;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 21;
  localparam logic [RECIP_W-1:0] RECIP_K = 15'd16514;

  // One slot table entry
  typedef struct packed {
    logic              important;
    logic [PRIO_W-1:0] prio;
  } slot_ent_t;

endpackage

>>> design/psa_if.sv
// Command channel: one word per command
interface psa_in_if import psa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot_in;
  logic [PRIO_W-1:0] prio;
  logic              important;
  logic [VOL_W-1:0]  max_vol;
  logic [VOL_W-1:0]  min_vol;

  modport source (output valid, cmd, slot_in, prio, important, max_vol, min_vol,
                  input ready);
  modport sink   (input valid, cmd, slot_in, prio, important, max_vol, min_vol,
                  output ready);
endinterface

// Result channel: one word per command
interface psa_out_if import psa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_out;
  logic              ok;
  logic              evicted;
  logic [VOL_W-1:0]  scaled_max_vol;
  logic [VOL_W-1:0]  scaled_min_vol;

  modport source (output valid, slot_out, ok, evicted, scaled_max_vol, scaled_min_vol,
                  input ready);
  modport sink   (input valid, slot_out, ok, evicted, scaled_max_vol, scaled_min_vol,
                  output ready);
endinterface

>>> design/priority_slot_allocator_core.sv
// Sequencing: remove, flush and unknown commands go from decode straight to the result word;
//   an add takes the free hint or scans the table, and on success writes the table and refreshes
//   the hint; the scan covers the effective slot count (active_slots capped at NUM_SLOTS).
// Throughput: one command at a time, set by the slot scan through the table RAM (one entry per
//   cycle) and the busy-bit sweep that rebuilds the free hint; input is ready again once the
//   result word is loaded. Reset: synchronous, active low; all slots free, hint at slot 0.
module priority_slot_allocator_core import psa_pkg::*; #(
  parameter int NUM_SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  psa_in_if.sink               in_ch,
  psa_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [SLOT_W-1:0] NoSlot   = SLOT_W'(NUM_SLOTS);
  localparam logic [CNT_W-1:0]  SlotsMax = CNT_W'(NUM_SLOTS);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECODE  = 6'b000010,
    S_SCAN    = 6'b000100,
    S_WRITE   = 6'b001000,
    S_REFRESH = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  // Control state
  state_t                 state_r, state_nxt;
  logic [VOL_W-1:0]       vol_scale_r, vol_scale_nxt;
  logic [ACT_W-1:0]       active_slots_r, active_slots_nxt;
  logic [NUM_SLOTS-1:0]   busy_r, busy_nxt;
  logic [IDX_W-1:0]       hint_r, hint_nxt;
  logic                   hint_vld_r, hint_vld_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;

  // Command word and working registers
  logic [CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]      handle_r, handle_nxt;
  logic [PRIO_W-1:0]      prio_r, prio_nxt;
  logic                   imp_r, imp_nxt;
  logic [CNT_W-1:0]       iss_r, iss_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]       pick_r, pick_nxt;
  logic                   from_scan_r, from_scan_nxt;
  logic [CNT_W-1:0]       ref_r, ref_nxt;
  logic [SLOT_W-1:0]      res_slot_r, res_slot_nxt;
  logic                   ok_r, ok_nxt;
  logic                   ev_r, ev_nxt;
  logic                   add_ok_r, add_ok_nxt;

  // Result word
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic                   out_ok_r, out_ok_nxt;
  logic                   out_ev_r, out_ev_nxt;
  logic [VOL_W-1:0]       out_smax_r, out_smax_nxt;
  logic [VOL_W-1:0]       out_smin_r, out_smin_nxt;

  // Slot table RAM: importance and priority, valid only where the busy bit is set
  slot_ent_t              slot_mem [NUM_SLOTS];
  slot_ent_t              rd_data_r;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;

  logic                   in_acc;
  logic [CNT_W-1:0]       eff_cnt;
  logic                   hint_ok;
  logic                   handle_ok;
  logic [IDX_W-1:0]       handle_idx;
  logic                   iss_in_range;
  logic                   cmp_free;
  logic                   cmp_evict;
  logic                   cmp_last;
  logic [VOL_W-1:0]       scaled_max;
  logic [VOL_W-1:0]       scaled_min;

  assign in_acc         = in_ch.valid && in_ch.ready;
  assign in_ch.ready    = (state_r == S_IDLE);

  assign out_ch.valid          = out_vld_r;
  assign out_ch.slot_out       = out_slot_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.evicted        = out_ev_r;
  assign out_ch.scaled_max_vol = out_smax_r;
  assign out_ch.scaled_min_vol = out_smin_r;

  // Effective slot count: active_slots capped at the table size
  assign eff_cnt = ({3'b000, active_slots_r} > 9'(NUM_SLOTS)) ? SlotsMax
                                                              : CNT_W'(active_slots_r);

  assign hint_ok    = hint_vld_r && (CNT_W'(hint_r) < eff_cnt) && !busy_r[hint_r];
  assign handle_ok  = ({3'b000, handle_r} < 9'(eff_cnt));
  assign handle_idx = IDX_W'(handle_r);

  // Scan pipeline: address issued one cycle, entry compared the next
  assign iss_in_range = (iss_r < eff_cnt);
  assign rd_addr      = IDX_W'(iss_r);
  assign cmp_free     = !busy_r[cmp_idx_r];
  assign cmp_evict    = !rd_data_r.important && (rd_data_r.prio <= prio_r);
  assign cmp_last     = ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == eff_cnt);

  assign mem_we = (state_r == S_WRITE);

  // Table RAM; the sequencer never reads while a write is in flight
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[pick_r] <= '{important: imp_r, prio: prio_r};
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  psa_vol_scale u_vol_scale (
    .clk        (clk),
    .load       (in_acc),
    .vol_scale  (vol_scale_r),
    .max_vol    (in_ch.max_vol),
    .min_vol    (in_ch.min_vol),
    .scaled_max (scaled_max),
    .scaled_min (scaled_min)
  );

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    vol_scale_nxt    = vol_scale_r;
    active_slots_nxt = active_slots_r;
    busy_nxt         = busy_r;
    hint_nxt         = hint_r;
    hint_vld_nxt     = hint_vld_r;
    out_vld_nxt      = out_vld_r;
    cmp_vld_nxt      = cmp_vld_r;
    cmd_nxt          = cmd_r;
    handle_nxt       = handle_r;
    prio_nxt         = prio_r;
    imp_nxt          = imp_r;
    iss_nxt          = iss_r;
    cmp_idx_nxt      = cmp_idx_r;
    pick_nxt         = pick_r;
    from_scan_nxt    = from_scan_r;
    ref_nxt          = ref_r;
    res_slot_nxt     = res_slot_r;
    ok_nxt           = ok_r;
    ev_nxt           = ev_r;
    add_ok_nxt       = add_ok_r;
    out_slot_nxt     = out_slot_r;
    out_ok_nxt       = out_ok_r;
    out_ev_nxt       = out_ev_r;
    out_smax_nxt     = out_smax_r;
    out_smin_nxt     = out_smin_r;

    // register writes
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_VOL_SCALE:    vol_scale_nxt    = cfg_wdata;
        REG_ACTIVE_SLOTS: active_slots_nxt = cfg_wdata[ACT_W-1:0];
        default: ;
      endcase
    end

    // output word taken
    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_ch.cmd;
          handle_nxt = in_ch.slot_in;
          prio_nxt   = in_ch.prio;
          imp_nxt    = in_ch.important;
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        res_slot_nxt = NoSlot;
        ok_nxt       = 1'b0;
        ev_nxt       = 1'b0;
        add_ok_nxt   = 1'b0;
        state_nxt    = S_DONE;
        unique case (cmd_r)
          CMD_ADD: begin
            if (eff_cnt == '0) begin
              // no slots at all: add fails
            end else if (hint_ok) begin
              pick_nxt      = hint_r;
              from_scan_nxt = 1'b0;
              ok_nxt        = 1'b1;
              add_ok_nxt    = 1'b1;
              res_slot_nxt  = SLOT_W'(hint_r);
              state_nxt     = S_WRITE;
            end else begin
              iss_nxt     = '0;
              cmp_vld_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
          end
          CMD_REMOVE: begin
            if (handle_ok) begin
              ok_nxt       = 1'b1;
              res_slot_nxt = handle_r;
              if (busy_r[handle_idx]) begin
                busy_nxt[handle_idx] = 1'b0;
                hint_nxt             = handle_idx;
                hint_vld_nxt         = 1'b1;
              end
            end
          end
          CMD_FLUSH: begin
            busy_nxt     = '0;
            hint_nxt     = '0;
            hint_vld_nxt = 1'b1;
            ok_nxt       = 1'b1;
          end
          default: ;
        endcase
      end

      S_SCAN: begin
        cmp_vld_nxt = iss_in_range;
        cmp_idx_nxt = IDX_W'(iss_r);
        if (iss_in_range) begin
          iss_nxt = iss_r + CNT_W'(1);
        end
        // first slot in index order that is free or evictable
        if (cmp_vld_r) begin
          if (cmp_free || cmp_evict) begin
            pick_nxt      = cmp_idx_r;
            from_scan_nxt = 1'b1;
            ok_nxt        = 1'b1;
            add_ok_nxt    = 1'b1;
            ev_nxt        = !cmp_free;
            res_slot_nxt  = SLOT_W'(cmp_idx_r);
            state_nxt     = S_WRITE;
          end else if (cmp_last) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_WRITE: begin
        busy_nxt[pick_r] = 1'b1;
        hint_vld_nxt     = 1'b0;
        // after a scan every slot below the pick is busy
        ref_nxt   = from_scan_r ? (CNT_W'(pick_r) + CNT_W'(1)) : '0;
        state_nxt = S_REFRESH;
      end

      S_REFRESH: begin
        if (ref_r < eff_cnt) begin
          if (!busy_r[IDX_W'(ref_r)]) begin
            hint_nxt     = IDX_W'(ref_r);
            hint_vld_nxt = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            ref_nxt = ref_r + CNT_W'(1);
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt  = 1'b1;
          out_slot_nxt = res_slot_r;
          out_ok_nxt   = ok_r;
          out_ev_nxt   = ev_r;
          out_smax_nxt = add_ok_r ? scaled_max : '0;
          out_smin_nxt = add_ok_r ? scaled_min : '0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      vol_scale_r    <= VOL_UNITY;
      active_slots_r <= ACTIVE_RESET;
      busy_r         <= '0;
      hint_r         <= '0;
      hint_vld_r     <= 1'b1;
      out_vld_r      <= 1'b0;
      cmp_vld_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      vol_scale_r    <= vol_scale_nxt;
      active_slots_r <= active_slots_nxt;
      busy_r         <= busy_nxt;
      hint_r         <= hint_nxt;
      hint_vld_r     <= hint_vld_nxt;
      out_vld_r      <= out_vld_nxt;
      cmp_vld_r      <= cmp_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    handle_r    <= handle_nxt;
    prio_r      <= prio_nxt;
    imp_r       <= imp_nxt;
    iss_r       <= iss_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    pick_r      <= pick_nxt;
    from_scan_r <= from_scan_nxt;
    ref_r       <= ref_nxt;
    res_slot_r  <= res_slot_nxt;
    ok_r        <= ok_nxt;
    ev_r        <= ev_nxt;
    add_ok_r    <= add_ok_nxt;
    out_slot_r  <= out_slot_nxt;
    out_ok_r    <= out_ok_nxt;
    out_ev_r    <= out_ev_nxt;
    out_smax_r  <= out_smax_nxt;
    out_smin_r  <= out_smin_nxt;
  end

endmodule

>>> design/psa_vol_scale.sv
// Volume scaler: v * scale / 127, truncating.
// Stage one registers the products, stage two is a constant reciprocal multiply.
module psa_vol_scale import psa_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic [VOL_W-1:0] vol_scale,
  input  logic [VOL_W-1:0] max_vol,
  input  logic [VOL_W-1:0] min_vol,
  output logic [VOL_W-1:0] scaled_max,
  output logic [VOL_W-1:0] scaled_min
);

  localparam int FULL_W = PROD_W + RECIP_W;

  logic [PROD_W-1:0] prod_max_r, prod_max_nxt;
  logic [PROD_W-1:0] prod_min_r, prod_min_nxt;
  logic [FULL_W-1:0] q_max_full;
  logic [FULL_W-1:0] q_min_full;

  // Capture products when a word is taken
  always_comb begin
    prod_max_nxt = prod_max_r;
    prod_min_nxt = prod_min_r;
    if (load) begin
      prod_max_nxt = PROD_W'(max_vol) * PROD_W'(vol_scale);
      prod_min_nxt = PROD_W'(min_vol) * PROD_W'(vol_scale);
    end
  end

  always_ff @(posedge clk) begin
    prod_max_r <= prod_max_nxt;
    prod_min_r <= prod_min_nxt;
  end

  // Reciprocal multiply in place of the divide
  assign q_max_full = FULL_W'(prod_max_r) * FULL_W'(RECIP_K);
  assign q_min_full = FULL_W'(prod_min_r) * FULL_W'(RECIP_K);

  assign scaled_max = q_max_full[RECIP_SHIFT +: VOL_W];
  assign scaled_min = q_min_full[RECIP_SHIFT +: VOL_W];

endmodule

>>> design/psa_checker.sv
// Port-level checks on the allocator
module psa_checker import psa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] out_slot,
  input logic              out_ok,
  input logic              out_evicted,
  input logic [VOL_W-1:0]  out_smax,
  input logic [VOL_W-1:0]  out_smin
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken in but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_ok)
      && $stable(out_evicted) && $stable(out_smax) && $stable(out_smin))
    else $error("result word changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input ready straight after a command was taken");

  // no result without a command behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result word with no command outstanding");

  // at most one in work plus one waiting
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many commands outstanding");

endmodule

bind priority_slot_allocator_core psa_checker u_psa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_slot    (out_ch.slot_out),
  .out_ok      (out_ch.ok),
  .out_evicted (out_ch.evicted),
  .out_smax    (out_ch.scaled_max_vol),
  .out_smin    (out_ch.scaled_min_vol)
);

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import psa_pkg::*;

  localparam int NUM_SLOTS = 32;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(NUM_SLOTS);
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 16;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot_in;
    logic [PRIO_W-1:0] prio;
    logic              important;
    logic [VOL_W-1:0]  max_vol;
    logic [VOL_W-1:0]  min_vol;
  } alloc_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              ok;
    logic              evicted;
    logic [VOL_W-1:0]  scaled_max_vol;
    logic [VOL_W-1:0]  scaled_min_vol;
  } alloc_res_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  psa_in_if  in_ch ();
  psa_out_if out_ch ();

  priority_slot_allocator_core #(.NUM_SLOTS(NUM_SLOTS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the slot table and registers
  bit               slot_busy [NUM_SLOTS];
  bit               slot_imp  [NUM_SLOTS];
  bit [PRIO_W-1:0]  slot_prio [NUM_SLOTS];
  int               free_hint;
  bit               hint_ok;
  int               vol_scale;
  int               act_slots;

  alloc_cmd_t cmd_backlog [$];
  alloc_res_t due_results [$];

  int errors;
  int n_adds, n_evicts, n_add_fails, n_removes, n_bad_handles, n_flushes, n_unknown;
  int n_words;

  bit tx_idle_on;
  bit rx_idle_on;
  int holds_asked;
  int holds_done;
  int hold_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int slot_count();
    return (act_slots > NUM_SLOTS) ? NUM_SLOTS : act_slots;
  endfunction

  function automatic logic [VOL_W-1:0] scale_code(logic [VOL_W-1:0] v);
    return VOL_W'((int'(v) * vol_scale) / int'(VOL_UNITY));
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_imp[i]  = 1'b0;
      slot_prio[i] = '0;
    end
    free_hint = 0;
    hint_ok   = 1'b1;
    vol_scale = 127;
    act_slots = 32;
  endfunction

  // Apply one command to the shadow table and return the word it gives
  function automatic alloc_res_t apply_command(alloc_cmd_t c);
    alloc_res_t r;
    int  n;
    int  pick;
    bit  found;
    bit  ev;
    r = '0;
    r.slot_out = NO_SLOT;
    n = slot_count();
    found = 1'b0;
    ev = 1'b0;
    pick = 0;
    case (c.cmd)
      CMD_ADD: begin
        if (hint_ok && free_hint < n && !slot_busy[free_hint]) begin
          pick = free_hint;
          found = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (!found) begin
              if (!slot_busy[i]) begin
                pick = i;
                found = 1'b1;
              end else if (slot_prio[i] <= c.prio && !slot_imp[i]) begin
                pick = i;
                found = 1'b1;
                ev = 1'b1;
              end
            end
          end
        end
        if (found) begin
          slot_busy[pick] = 1'b1;
          slot_imp[pick]  = c.important;
          slot_prio[pick] = c.prio;
          // lowest free slot becomes the new hint
          hint_ok = 1'b0;
          for (int i = 0; i < n; i++) begin
            if (!hint_ok && !slot_busy[i]) begin
              free_hint = i;
              hint_ok = 1'b1;
            end
          end
          r.slot_out = SLOT_W'(pick);
          r.ok = 1'b1;
          r.evicted = ev;
          r.scaled_max_vol = scale_code(c.max_vol);
          r.scaled_min_vol = scale_code(c.min_vol);
          n_adds++;
          if (ev) n_evicts++;
        end else begin
          n_add_fails++;
        end
      end
      CMD_REMOVE: begin
        if (int'(c.slot_in) >= n) begin
          n_bad_handles++;
        end else begin
          if (slot_busy[c.slot_in]) begin
            slot_busy[c.slot_in] = 1'b0;
            free_hint = int'(c.slot_in);
            hint_ok = 1'b1;
          end
          r.slot_out = c.slot_in;
          r.ok = 1'b1;
          n_removes++;
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < NUM_SLOTS; i++) slot_busy[i] = 1'b0;
        free_hint = 0;
        hint_ok = 1'b1;
        r.ok = 1'b1;
        n_flushes++;
      end
      default: begin
        n_unknown++;
      end
    endcase
    return r;
  endfunction

  // Gap lengths: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic alloc_cmd_t make_cmd(logic [CMD_W-1:0] cmd, int slot, int prio, bit imp,
                                          int maxv, int minv);
    alloc_cmd_t c;
    c.cmd = cmd;
    c.slot_in = SLOT_W'(slot);
    c.prio = PRIO_W'(prio);
    c.important = imp;
    c.max_vol = VOL_W'(maxv);
    c.min_vol = VOL_W'(minv);
    return c;
  endfunction

  function automatic logic [VOL_W-1:0] random_vol();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VOL_W'($urandom_range(0, 127));
  endfunction

  // Random command: mostly adds and in-range removes, the rest noise
  function automatic alloc_cmd_t random_command(int n, int add_pct, int rem_pct, int flush_pct);
    alloc_cmd_t c;
    int r;
    int h;
    c.cmd = CMD_ADD;
    c.slot_in = SLOT_W'($urandom_range(0, 63));
    r = $urandom_range(0, 9);
    c.prio = (r < 2) ? 8'd0 : (r < 4) ? 8'hff : PRIO_W'($urandom_range(0, 255));
    c.important = ($urandom_range(0, 4) == 0);
    c.max_vol = random_vol();
    c.min_vol = random_vol();
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      c.cmd = CMD_ADD;
    end else if (r < add_pct + rem_pct) begin
      c.cmd = CMD_REMOVE;
      h = $urandom_range(0, 9);
      if (h == 0) c.slot_in = NO_SLOT;
      else if (h > 1 && n > 0) c.slot_in = SLOT_W'($urandom_range(0, n - 1));
    end else if (r < add_pct + rem_pct + flush_pct) begin
      c.cmd = CMD_FLUSH;
    end else begin
      c.cmd = ($urandom_range(0, 1) == 0) ? CMD_UNUSED : CMD_REMOVE;
    end
    return c;
  endfunction

  // Driver: presents backlog words, predicts each at acceptance
  alloc_cmd_t tx_word;
  int tx_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        due_results.push_back(apply_command(tx_word));
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          tx_word = cmd_backlog.pop_front();
          in_ch.cmd       <= tx_word.cmd;
          in_ch.slot_in   <= tx_word.slot_in;
          in_ch.prio      <= tx_word.prio;
          in_ch.important <= tx_word.important;
          in_ch.max_vol   <= tx_word.max_vol;
          in_ch.min_vol   <= tx_word.min_vol;
          in_ch.valid     <= 1'b1;
          tx_gap = tx_idle_on ? pick_gap() : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
    end
  end

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: checks each result word against the oldest prediction
  int rx_stall;
  alloc_res_t rx_exp;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_words++;
        if (due_results.size() == 0) begin
          $error("result word with nothing outstanding: slot_out %0d ok %0d",
                 out_ch.slot_out, out_ch.ok);
          errors++;
        end else begin
          rx_exp = due_results.pop_front();
          compare_field("slot_out", rx_exp.slot_out, out_ch.slot_out);
          compare_field("ok", rx_exp.ok, out_ch.ok);
          compare_field("evicted", rx_exp.evicted, out_ch.evicted);
          compare_field("scaled_max_vol", rx_exp.scaled_max_vol, out_ch.scaled_max_vol);
          compare_field("scaled_min_vol", rx_exp.scaled_min_vol, out_ch.scaled_min_vol);
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        rx_stall = rx_idle_on ? pick_gap() : 0;
        out_ch.ready <= (rx_stall == 0);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_VOL_SCALE) vol_scale = int'(val);
    else act_slots = int'(val[ACT_W-1:0]);
  endtask

  task automatic set_config(int scale, int slots);
    write_reg(REG_VOL_SCALE, CFG_W'(scale));
    write_reg(REG_ACTIVE_SLOTS, CFG_W'(slots));
    @(negedge clk);
  endtask

  // Wait until every queued word is accepted and answered
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic random_phase(int scale, int slots, int count, int add_pct, int rem_pct,
                              int flush_pct, bit idle, bit pressure);
    int n;
    set_config(scale, slots);
    n = slot_count();
    tx_idle_on <= idle;
    rx_idle_on <= idle;
    for (int i = 0; i < count; i++)
      cmd_backlog.push_back(random_command(n, add_pct, rem_pct, flush_pct));
    if (pressure) begin
      @(negedge clk);
      holds_asked <= holds_asked + 1;
    end
    drain();
  endtask

  // Stimulus
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_VOL_SCALE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ADD;
    in_ch.slot_in = '0;
    in_ch.prio = '0;
    in_ch.important = 1'b0;
    in_ch.max_vol = '0;
    in_ch.min_vol = '0;
    out_ch.ready = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    holds_asked = 0;
    errors = 0;
    n_words = 0;
    table_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset settings: volume extremes, hint after remove, handles
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 0, 0, 127, 0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 255, 1, 0, 127));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 128, 0, 127, 127));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 1, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 63, 7, 0, 1, 126));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 5, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, NUM_SLOTS, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 63, 255, 1, 127, 127));
    cmd_backlog.push_back(make_cmd(CMD_UNUSED, 63, 255, 1, 127, 127));
    cmd_backlog.push_back(make_cmd(CMD_FLUSH, 63, 255, 1, 127, 127));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 1, 0, 64, 63));
    drain();

    // Three slots: fill, no hint, failed add, eviction at equal priority
    set_config(64, 3);
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 50, 1, 127, 1));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 100, 0, 100, 2));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 200, 0, 3, 127));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 99, 0, 90, 90));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 100, 0, 80, 40));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 2, 0, 0, 0, 0));
    drain();

    // Two slots: hint beyond the count, all important, handle beyond the count
    set_config(0, 2);
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 255, 1, 127, 127));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 255, 0, 127, 127));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 2, 0, 0, 0, 0));
    drain();

    // No slots at all
    set_config(1, 0);
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 255, 0, 127, 127));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_FLUSH, 0, 0, 0, 0, 0));
    drain();

    // Count above the table size saturates
    set_config(127, 7'h7f);
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 9, 0, 127, 127));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 31, 0, 0, 0, 0));
    drain();

    // Random phases across scale and slot count settings
    random_phase(64, 32, 400, 70, 20, 1, 1'b1, 1'b0);
    random_phase(1, 4, 200, 55, 30, 5, 1'b1, 1'b0);
    random_phase(100, 1, 100, 50, 35, 5, 1'b1, 1'b0);
    random_phase(0, 7'h7f, 300, 72, 20, 1, 1'b1, 1'b0);
    random_phase(127, 8, 250, 60, 28, 3, 1'b1, 1'b1);
    random_phase($urandom_range(0, 127), 0, 30, 50, 30, 10, 1'b1, 1'b0);
    random_phase($urandom_range(0, 127), 16, 250, 65, 25, 2, 1'b0, 1'b0);
    random_phase(127, 40, 270, 68, 22, 2, 1'b1, 1'b0);

    // Let any stray word show up before the verdict
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d result words: %0d adds (%0d evictions, %0d refused), %0d removes,",
             n_words, n_adds, n_evicts, n_add_fails, n_removes);
    $display("  %0d bad handles, %0d flushes, %0d unknown commands, over 13 settings",
             n_bad_handles, n_flushes, n_unknown);
    if (errors == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (due_results.size() != 0)
        $error("%0d result words never arrived", due_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
